// ===== hdl/tsrl_pkg.sv =====
package tsrl_pkg;

    localparam int CAPACITY_DEF    = 128;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int TIME_W          = 63;
    localparam int HANDLE_W        = 16;
    localparam int OUT_CNT_W       = 8;

    // slave tdata layout
    localparam int S_START_LO  = 0;
    localparam int S_END_LO    = S_START_LO + TIME_W;
    localparam int S_HANDLE_LO = S_END_LO + TIME_W;
    localparam int S_CUTOFF_LO = S_HANDLE_LO + HANDLE_W;
    localparam int S_USED_W    = S_CUTOFF_LO + TIME_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // master tdata layout
    localparam int M_USED_W  = 1 + 3 * OUT_CNT_W + 1 + 2 * TIME_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef logic signed [TIME_W-1:0] time_val_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_REM_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        time_val_t  key_start;
        time_val_t  key_end;
    } cell_cmd_t;

endpackage

// ===== hdl/tsrl_cell.sv =====
module tsrl_cell
    import tsrl_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                              clk,
    input  cell_cmd_t                         cmd,
    input  logic [HANDLE_BITS-1:0]            new_handle,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    input  logic                              prev_le,
    input  time_val_t                         prev_start,
    input  time_val_t                         prev_stop,
    input  logic [HANDLE_BITS-1:0]            prev_handle,
    input  time_val_t                         next_start,
    input  time_val_t                         next_stop,
    input  logic [HANDLE_BITS-1:0]            next_handle,
    output time_val_t                         start_out,
    output time_val_t                         stop_out,
    output logic [HANDLE_BITS-1:0]            handle,
    output logic                              le
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    time_val_t              start_reg, start_next;
    time_val_t              stop_reg, stop_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic                   valid;

    assign valid = count > IDX_C;
    assign le    = valid && (start_reg <= cmd.key_start);

    always_comb
    begin
        start_next  = start_reg;
        stop_next   = stop_reg;
        handle_next = handle_reg;
        case (cmd.mode)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    if (prev_le)
                    begin
                        start_next  = cmd.key_start;
                        stop_next   = cmd.key_end;
                        handle_next = new_handle;
                    end
                    else
                    begin
                        start_next  = prev_start;
                        stop_next   = prev_stop;
                        handle_next = prev_handle;
                    end
                end
            end
            CELL_SHIFT:
            begin
                start_next  = next_start;
                stop_next   = next_stop;
                handle_next = next_handle;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        stop_reg   <= stop_next;
        handle_reg <= handle_next;
    end

    assign start_out = start_reg;
    assign stop_out  = stop_reg;
    assign handle    = handle_reg;

endmodule

// ===== hdl/time_sorted_record_list.sv =====
// Sorted list of record descriptors held in a row of cells, one entry per cell,
// ordered by start time. An insert moves the row as the beat is taken, then finds
// the insert position by a binary search over the captured compare vector; an
// insert into a full list skips the search and reports the full status. A remove
// drops one entry per cycle from the front while its end time lies before the
// cutoff. The result sits in an output register, so the next beat may be taken
// while it waits.
module time_sorted_record_list
    import tsrl_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // rec_start[62:0], rec_end[125:63], handle[141:126], cutoff_time[204:142], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[0], position[8:1], removed_count[16:9], count_now[24:17],
    // list_empty[25], first_start[88:26], last_end[151:89]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CW  = $clog2(CAPACITY+1);
    localparam int B   = $clog2(CAPACITY);
    localparam int PW  = B + 1;
    localparam int SBW = $clog2(B+1);
    localparam logic [CW-1:0]  CAP_C = CW'(CAPACITY);
    localparam logic [PW-1:0]  CAP_P = PW'(CAPACITY);
    localparam logic [SBW-1:0] SB_TOP = SBW'(B-1);

    state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       removed_reg, removed_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [SBW-1:0]      sb_reg, sb_next;
    logic                status_reg, status_next;
    logic [CAPACITY-1:0] le_vec_reg, le_vec_next;
    time_val_t           cutoff_reg, cutoff_next;
    time_val_t           new_end_reg, new_end_next;
    time_val_t           last_end_reg, last_end_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    cell_cmd_t cmd;
    logic      accept;
    logic      in_op;
    time_val_t in_start, in_end, in_cutoff;
    logic [HANDLE_W-1:0]             in_handle;
    logic [HANDLE_BITS+HANDLE_W-1:0] handle_ext;
    logic [HANDLE_BITS-1:0]          new_handle;

    time_val_t              c_start  [CAPACITY];
    time_val_t              c_stop   [CAPACITY];
    logic [HANDLE_BITS-1:0] c_handle [CAPACITY];
    logic [CAPACITY-1:0]    le_vec;

    logic [PW-1:0] probe;
    logic [PW-1:0] probe_idx;
    logic          probe_hit;
    logic          do_shift;
    logic          list_full;
    logic          empty_now;
    time_val_t     out_first, out_last;
    logic [CW+OUT_CNT_W-1:0] count_ext, removed_ext;
    logic [PW+OUT_CNT_W-1:0] pos_ext;

    assign in_op      = s_tuser;
    assign in_start   = s_tdata[S_START_LO +: TIME_W];
    assign in_end     = s_tdata[S_END_LO +: TIME_W];
    assign in_handle  = s_tdata[S_HANDLE_LO +: HANDLE_W];
    assign in_cutoff  = s_tdata[S_CUTOFF_LO +: TIME_W];
    assign handle_ext = {{HANDLE_BITS{1'b0}}, in_handle};
    assign new_handle = handle_ext[HANDLE_BITS-1:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign list_full = count_reg >= CAP_C;
    assign do_shift  = (state_reg == S_REM_SCAN) && (count_reg != '0)
                       && (c_stop[0] < cutoff_reg);

    always_comb
    begin
        cmd.key_start = in_start;
        cmd.key_end   = in_end;
        if (accept && (in_op == OP_INSERT) && !list_full)
            cmd.mode = CELL_INSERT;
        else if (do_shift)
            cmd.mode = CELL_SHIFT;
        else
            cmd.mode = CELL_HOLD;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                   p_le;
            time_val_t              p_start, p_stop, n_start, n_stop;
            logic [HANDLE_BITS-1:0] p_handle, n_handle;

            if (i == 0)
            begin : g_first
                assign p_le     = 1'b1;
                assign p_start  = in_start;
                assign p_stop   = in_end;
                assign p_handle = new_handle;
            end
            else
            begin : g_mid
                assign p_le     = le_vec[i-1];
                assign p_start  = c_start[i-1];
                assign p_stop   = c_stop[i-1];
                assign p_handle = c_handle[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_last
                assign n_start  = c_start[i];
                assign n_stop   = c_stop[i];
                assign n_handle = c_handle[i];
            end
            else
            begin : g_inner
                assign n_start  = c_start[i+1];
                assign n_stop   = c_stop[i+1];
                assign n_handle = c_handle[i+1];
            end

            tsrl_cell #(
                .IDX         (i),
                .CAPACITY    (CAPACITY),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .new_handle  (new_handle),
                .count       (count_reg),
                .prev_le     (p_le),
                .prev_start  (p_start),
                .prev_stop   (p_stop),
                .prev_handle (p_handle),
                .next_start  (n_start),
                .next_stop   (n_stop),
                .next_handle (n_handle),
                .start_out   (c_start[i]),
                .stop_out    (c_stop[i]),
                .handle      (c_handle[i]),
                .le          (le_vec[i])
            );
        end
    endgenerate

    // binary search for the length of the le prefix
    assign probe     = acc_reg + ({{(PW-1){1'b0}}, 1'b1} << sb_reg);
    assign probe_idx = probe - {{(PW-1){1'b0}}, 1'b1};
    assign probe_hit = (probe <= CAP_P) ? le_vec_reg[probe_idx[B-1:0]] : 1'b0;

    assign empty_now   = (count_reg == '0);
    assign out_first   = empty_now ? '1 : c_start[0];
    assign out_last    = empty_now ? '1 : last_end_reg;
    assign count_ext   = {{OUT_CNT_W{1'b0}}, count_reg};
    assign removed_ext = {{OUT_CNT_W{1'b0}}, removed_reg};
    assign pos_ext     = {{OUT_CNT_W{1'b0}}, acc_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        removed_next  = removed_reg;
        acc_next      = acc_reg;
        sb_next       = sb_reg;
        status_next   = status_reg;
        le_vec_next   = le_vec_reg;
        cutoff_next   = cutoff_reg;
        new_end_next  = new_end_reg;
        last_end_next = last_end_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_next     = '0;
                    removed_next = '0;
                    status_next  = ST_DONE;
                    cutoff_next  = in_cutoff;
                    new_end_next = in_end;
                    if (in_op == OP_REMOVE)
                        state_next = S_REM_SCAN;
                    else if (list_full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        le_vec_next = le_vec;
                        count_next  = count_reg + 1'b1;
                        sb_next     = SB_TOP;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (probe_hit)
                    acc_next = probe;
                if (sb_reg == '0)
                begin
                    if ((probe_hit ? probe : acc_reg) == PW'(count_reg - 1'b1))
                        last_end_next = new_end_reg;
                    state_next = S_DONE;
                end
                else
                    sb_next = sb_reg - 1'b1;
            end
            S_REM_SCAN:
            begin
                if (do_shift)
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0]      = status_reg;
                    m_tdata_next[8:1]    = pos_ext[OUT_CNT_W-1:0];
                    m_tdata_next[16:9]   = removed_ext[OUT_CNT_W-1:0];
                    m_tdata_next[24:17]  = count_ext[OUT_CNT_W-1:0];
                    m_tdata_next[25]     = empty_now;
                    m_tdata_next[88:26]  = out_first;
                    m_tdata_next[151:89] = out_last;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg  <= removed_next;
        acc_reg      <= acc_next;
        sb_reg       <= sb_next;
        status_reg   <= status_next;
        le_vec_reg   <= le_vec_next;
        cutoff_reg   <= cutoff_next;
        new_end_reg  <= new_end_next;
        last_end_reg <= last_end_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_INSERT) && !list_full)
        |=> (count_reg == $past(count_reg) + 1'b1) && (state_reg == S_SEARCH))
        else $error("insert did not add an entry");

    a_shift_drops: assert property (@(posedge clk) disable iff (!rst_n)
        do_shift |=> (count_reg == $past(count_reg) - 1'b1)
                     && (removed_reg == $past(removed_reg) + 1'b1))
        else $error("remove step did not drop one entry");

    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (count_reg >= CW'(2))) |-> (c_start[0] <= c_start[1]))
        else $error("front entries out of order");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && m_tvalid_reg && !m_tready) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule
